// ----- rtl/dsp_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package dsp_pkg;

   localparam int NODE_W   = 6;
   localparam int NCNT_W   = 7;
   localparam int WEIGHT_W = 16;
   localparam int DIST_W   = 32;
   localparam int CSR_W    = 7;

   localparam logic        CSR_NODE_COUNT  = 1'b0;
   localparam logic        CSR_SOURCE_NODE = 1'b1;
   localparam logic        FUNC_LOAD       = 1'b0;
   localparam logic        FUNC_RUN        = 1'b1;
   localparam logic [DIST_W-1:0] DIST_UNREACHED = 32'h7FFF_FFFF;

   typedef struct packed {
      logic                       func;
      logic [NODE_W-1:0]          from_node;
      logic [NODE_W-1:0]          to_node;
      logic signed [WEIGHT_W-1:0] edge_weight;
   } req_type;

   typedef struct packed {
      logic [NODE_W-1:0]        node_index;
      logic signed [DIST_W-1:0] distance;
      logic                     reachable;
      logic                     edges_dropped;
      logic                     last_result;
   } rsp_type;

   typedef struct packed {
      logic [NODE_W-1:0]   from_node;
      logic [NODE_W-1:0]   to_node;
      logic [WEIGHT_W-1:0] weight;
   } edge_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_ROOT, ST_D_RD, ST_D_EV, ST_D_POP,
      ST_R_INIT, ST_R_K, ST_R_U, ST_R_DU, ST_R_RD, ST_R_EV, ST_R_DT,
      ST_O_RD, ST_O_WR
   } state_type;

endpackage
`default_nettype wire

// ----- rtl/dag_shortest_path_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Single-source shortest paths on a loaded directed graph. A load transaction
// (func 0) stores one edge and gives no result; edges past MAX_EDGES or
// naming nodes at or above node_count are dropped and flagged. A run
// transaction (func 1) does a depth-first ordering (edges held in a
// single-port-read RAM), then relaxes edges in reverse finishing order (a
// distance read-modify-write for each matching edge), then emits one result
// per node, holding each result until rsp_ready takes it.
// A run empties the edge store. No clearing pass.
module dag_shortest_path_core
   import dsp_pkg::*;
#(
   parameter int MAX_NODES = 64,
   parameter int MAX_EDGES = 256
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire req_type           req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output rsp_type                rsp_data,
   input  wire logic              csr_we,
   input  wire logic              csr_index,
   input  wire logic [CSR_W-1:0]  csr_wdata
);
   localparam int NODE_AW = $clog2(MAX_NODES);
   localparam int EDGE_AW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
   localparam int ECNT_W  = $clog2(MAX_EDGES + 1);
   localparam int STK_W   = NODE_W + ECNT_W;
   localparam logic [NCNT_W-1:0] MAX_N = NCNT_W'(MAX_NODES);
   localparam logic [ECNT_W-1:0] MAX_E = ECNT_W'(MAX_EDGES);

   state_type state_ff, state_in;

   logic [NCNT_W-1:0]    node_count_ff;
   logic [NODE_W-1:0]    source_ff;
   logic [ECNT_W-1:0]    total_ff;
   logic                 dropped_ff;
   logic [MAX_NODES-1:0] visited_ff;
   logic [MAX_NODES-1:0] reached_ff;
   logic [NCNT_W-1:0]    root_ff;
   logic [NCNT_W-1:0]    depth_ff;
   logic [NCNT_W-1:0]    fin_ff;
   logic [NCNT_W-1:0]    k_ff;
   logic [NCNT_W-1:0]    idx_ff;
   logic [NODE_W-1:0]    u_ff;
   logic [NODE_W-1:0]    t_ff;
   logic [ECNT_W-1:0]    e_ff;
   logic [WEIGHT_W-1:0]  w_ff;
   logic [DIST_W-1:0]    du_ff;
   logic                 rsp_valid_ff;
   rsp_type              rsp_ff;

   logic [NCNT_W-1:0] n_act;
   logic              rsp_free;
   logic              edge_hit;
   logic              push;
   logic [DIST_W-1:0] cand;
   logic              better;

   logic                  e_we;
   logic [EDGE_AW-1:0]    e_waddr, e_raddr;
   edge_type              e_wdata, e_rdata;
   logic                  s_we;
   logic [NODE_AW-1:0]    s_waddr, s_raddr;
   logic [STK_W-1:0]      s_wdata, s_rdata;
   logic                  f_we;
   logic [NODE_AW-1:0]    f_waddr, f_raddr;
   logic [NODE_W-1:0]     f_wdata, f_rdata;
   logic                  d_we;
   logic [NODE_AW-1:0]    d_waddr, d_raddr;
   logic [DIST_W-1:0]     d_wdata, d_rdata;

   assign n_act    = (node_count_ff > MAX_N) ? MAX_N : node_count_ff;
   assign rsp_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign edge_hit = (e_rdata.from_node == u_ff) &&
                     ({1'b0, e_rdata.to_node} < n_act);
   assign push = edge_hit && !visited_ff[e_rdata.to_node[NODE_AW-1:0]];
   assign cand = du_ff + {{(DIST_W-WEIGHT_W){w_ff[WEIGHT_W-1]}}, w_ff};
   assign better = !reached_ff[t_ff[NODE_AW-1:0]] ||
                   ($signed(cand) < $signed(d_rdata));

   dsp_ram #(.WIDTH($bits(edge_type)), .DEPTH(MAX_EDGES)) u_edge_ram (
      .clock(clock), .we(e_we), .waddr(e_waddr), .wdata(e_wdata),
      .raddr(e_raddr), .rdata(e_rdata));
   dsp_ram #(.WIDTH(STK_W), .DEPTH(MAX_NODES)) u_stack_ram (
      .clock(clock), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
      .raddr(s_raddr), .rdata(s_rdata));
   dsp_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_order_ram (
      .clock(clock), .we(f_we), .waddr(f_waddr), .wdata(f_wdata),
      .raddr(f_raddr), .rdata(f_rdata));
   dsp_ram #(.WIDTH(DIST_W), .DEPTH(MAX_NODES)) u_dist_ram (
      .clock(clock), .we(d_we), .waddr(d_waddr), .wdata(d_wdata),
      .raddr(d_raddr), .rdata(d_rdata));

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_data.func == FUNC_RUN) state_in = ST_ROOT;
         end
         ST_ROOT: begin
            if (root_ff >= n_act) state_in = ST_R_INIT;
            else if (!visited_ff[root_ff[NODE_AW-1:0]]) state_in = ST_D_RD;
         end
         ST_D_RD: begin
            if (e_ff < total_ff) state_in = ST_D_EV;
            else if (depth_ff == NCNT_W'(1)) state_in = ST_ROOT;
            else state_in = ST_D_POP;
         end
         ST_D_EV:   state_in = ST_D_RD;
         ST_D_POP:  state_in = ST_D_RD;
         ST_R_INIT: state_in = ST_R_K;
         ST_R_K:    state_in = (k_ff == '0) ? ST_O_RD : ST_R_U;
         ST_R_U:    state_in = reached_ff[f_rdata[NODE_AW-1:0]] ? ST_R_DU : ST_R_K;
         ST_R_DU:   state_in = ST_R_RD;
         ST_R_RD:   state_in = (e_ff < total_ff) ? ST_R_EV : ST_R_K;
         ST_R_EV:   state_in = edge_hit ? ST_R_DT : ST_R_RD;
         ST_R_DT:   state_in = ST_R_RD;
         ST_O_RD:   state_in = (idx_ff >= n_act) ? ST_IDLE : ST_O_WR;
         ST_O_WR: begin
            if (rsp_free) state_in = ST_O_RD;
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      e_we    = 1'b0;
      e_waddr = total_ff[EDGE_AW-1:0];
      e_wdata = '{from_node: req_data.from_node, to_node: req_data.to_node,
                  weight: req_data.edge_weight};
      e_raddr = e_ff[EDGE_AW-1:0];
      s_we    = 1'b0;
      s_waddr = NODE_AW'(depth_ff - NCNT_W'(1));
      s_wdata = {u_ff, e_ff + ECNT_W'(1)};
      s_raddr = NODE_AW'(depth_ff - NCNT_W'(2));
      f_we    = 1'b0;
      f_waddr = fin_ff[NODE_AW-1:0];
      f_wdata = u_ff;
      f_raddr = NODE_AW'(k_ff - NCNT_W'(1));
      d_we    = 1'b0;
      d_waddr = t_ff[NODE_AW-1:0];
      d_wdata = cand;
      d_raddr = idx_ff[NODE_AW-1:0];
      case (state_ff)
         ST_IDLE: begin
            e_we = req_valid && req_data.func == FUNC_LOAD && total_ff < MAX_E &&
                   {1'b0, req_data.from_node} < n_act &&
                   {1'b0, req_data.to_node} < n_act;
         end
         ST_D_RD:  f_we = (e_ff >= total_ff);
         ST_D_EV:  s_we = push;
         ST_R_INIT: begin
            d_we    = ({1'b0, source_ff} < n_act);
            d_waddr = source_ff[NODE_AW-1:0];
            d_wdata = '0;
         end
         ST_R_U:   d_raddr = f_rdata[NODE_AW-1:0];
         ST_R_EV:  d_raddr = e_rdata.to_node[NODE_AW-1:0];
         ST_R_DT:  d_we = better;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         node_count_ff <= NCNT_W'(64);
         source_ff     <= '0;
         total_ff      <= '0;
         dropped_ff    <= 1'b0;
         visited_ff    <= '0;
         reached_ff    <= '0;
         root_ff       <= '0;
         fin_ff        <= '0;
         depth_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= (state_ff == ST_O_WR && rsp_free) ||
                         (rsp_valid_ff && !rsp_ready);
         if (csr_we) begin
            case (csr_index)
               CSR_NODE_COUNT:  node_count_ff <= csr_wdata;
               CSR_SOURCE_NODE: source_ff     <= csr_wdata[NODE_W-1:0];
               default: ;
            endcase
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_valid && req_data.func == FUNC_LOAD) begin
                  if (e_we) total_ff <= total_ff + ECNT_W'(1);
                  else dropped_ff <= 1'b1;
               end
               root_ff    <= '0;
               fin_ff     <= '0;
               depth_ff   <= '0;
               reached_ff <= '0;
            end
            ST_ROOT: begin
               if (root_ff < n_act) begin
                  root_ff <= root_ff + NCNT_W'(1);
                  if (!visited_ff[root_ff[NODE_AW-1:0]]) begin
                     visited_ff[root_ff[NODE_AW-1:0]] <= 1'b1;
                     u_ff     <= root_ff[NODE_W-1:0];
                     e_ff     <= '0;
                     depth_ff <= NCNT_W'(1);
                  end
               end
            end
            ST_D_RD: begin
               if (e_ff >= total_ff) begin
                  fin_ff   <= fin_ff + NCNT_W'(1);
                  depth_ff <= depth_ff - NCNT_W'(1);
               end
            end
            ST_D_EV: begin
               if (push) begin
                  visited_ff[e_rdata.to_node[NODE_AW-1:0]] <= 1'b1;
                  u_ff     <= e_rdata.to_node;
                  e_ff     <= '0;
                  depth_ff <= depth_ff + NCNT_W'(1);
               end else begin
                  e_ff <= e_ff + ECNT_W'(1);
               end
            end
            ST_D_POP: begin
               u_ff <= s_rdata[STK_W-1:ECNT_W];
               e_ff <= s_rdata[ECNT_W-1:0];
            end
            ST_R_INIT: begin
               if ({1'b0, source_ff} < n_act) reached_ff[source_ff[NODE_AW-1:0]] <= 1'b1;
               k_ff <= fin_ff;
               idx_ff <= '0;
            end
            ST_R_U: begin
               u_ff <= f_rdata;
               k_ff <= k_ff - NCNT_W'(1);
            end
            ST_R_DU: begin
               du_ff <= d_rdata;
               e_ff  <= '0;
            end
            ST_R_EV: begin
               e_ff <= e_ff + ECNT_W'(1);
               t_ff <= e_rdata.to_node;
               w_ff <= e_rdata.weight;
            end
            ST_R_DT: begin
               if (better) begin
                  reached_ff[t_ff[NODE_AW-1:0]] <= 1'b1;
                  if (t_ff == u_ff) du_ff <= cand;
               end
            end
            ST_O_RD: begin
               if (idx_ff >= n_act) begin
                  visited_ff <= '0;
                  total_ff   <= '0;
                  dropped_ff <= 1'b0;
               end
            end
            ST_O_WR: begin
               if (rsp_free) begin
                  rsp_ff.node_index    <= idx_ff[NODE_W-1:0];
                  rsp_ff.reachable     <= reached_ff[idx_ff[NODE_AW-1:0]];
                  rsp_ff.distance      <= reached_ff[idx_ff[NODE_AW-1:0]] ?
                                          d_rdata : DIST_UNREACHED;
                  rsp_ff.edges_dropped <= dropped_ff;
                  rsp_ff.last_result   <= (idx_ff + NCNT_W'(1) == n_act);
                  idx_ff <= idx_ff + NCNT_W'(1);
               end
            end
            default: ;
         endcase
      end
   end

   a_total_bound: assert property (@(posedge clock) disable iff (reset)
      total_ff <= MAX_E) else $error("edge count above capacity");
   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      depth_ff <= MAX_N) else $error("walk stack overflow");
   a_fin_bound: assert property (@(posedge clock) disable iff (reset)
      fin_ff <= n_act || state_ff == ST_IDLE) else $error("finish order overrun");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |=> rsp_valid_ff) else $error("result lost");
endmodule
`default_nettype wire

// ----- rtl/dsp_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
module dsp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                                    clock,
   input  wire logic                                    we,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  wire logic [WIDTH-1:0]                        wdata,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic      [WIDTH-1:0]                        rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule
`default_nettype wire
